/* src/abt_pkg.sv */
// shared constants and register codes for the alias table builder
package abt_pkg;

	localparam int DEF_MAX_OUTCOMES = 64;
	localparam int PROB_W           = 25;
	localparam int TAG_W            = 8;
	localparam int CNT_W            = 7;
	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 25;

	localparam logic [PROB_W-1:0] ONE_Q24 = PROB_W'(1) << 24;

	localparam logic [CNT_W-1:0]  RST_OUTCOME_COUNT = CNT_W'(64);
	localparam logic [PROB_W-1:0] RST_EQUAL_SHARE   = PROB_W'(262144);

	localparam logic [CFG_IDX_W-1:0] REG_OUTCOME_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EQUAL_SHARE   = 1'b1;

endpackage

/* src/abt_ifs.sv */
// valid/ready channels: input words, queued words and result words

interface abt_in_if import abt_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [PROB_W-1:0] probability;
	logic [TAG_W-1:0]  table_tag;
	logic              row_end;
	modport source(output valid, probability, table_tag, row_end, input ready);
	modport sink(input valid, probability, table_tag, row_end, output ready);
endinterface

interface abt_item_if import abt_pkg::*; #(parameter int IW = 6);
	logic              valid;
	logic              ready;
	logic [IW-1:0]     idx;
	logic [PROB_W-1:0] prob;
	logic [TAG_W-1:0]  tag;
	logic              first;
	logic              row_last;
	modport source(output valid, idx, prob, tag, first, row_last, input ready);
	modport sink(input valid, idx, prob, tag, first, row_last, output ready);
endinterface

interface abt_out_if import abt_pkg::*; #(parameter int IW = 6);
	logic              valid;
	logic              ready;
	logic [IW-1:0]     outcome_index;
	logic [IW-1:0]     alias_index;
	logic [PROB_W-1:0] keep_probability;
	logic [TAG_W-1:0]  tag_out;
	logic              entry_invalid;
	logic              last_out;
	modport source(output valid, outcome_index, alias_index, keep_probability, tag_out,
		entry_invalid, last_out, input ready);
	modport sink(input valid, outcome_index, alias_index, keep_probability, tag_out,
		entry_invalid, last_out, output ready);
endinterface

/* src/alias_table_builder.sv */
// top level of the alias table builder: config registers, front end and back end
//
// Takes one row of outcome probabilities in UQ1.24 (one word per outcome, the
// row closes on row_end or after outcome_count words) and builds a Walker
// alias table for it, then returns one result word per outcome in order
// 0..n-1, with n = outcome_count held to 2..MAX_OUTCOMES. Loading takes one
// word per cycle while the queue has room. After the last word, build rounds
// run (select by priority encoders over per-outcome flags, then a residual
// read and update on the 2-read / 1-write residual memory); there is one
// round per outcome that receives an alias, at most n, plus one closing
// select. Results then drain one outcome at a time (alias and keep memory
// read, then the output register). The next row's words are taken while
// results drain, up to its last word, which waits for the drain to finish.
// A small queue between the front and back ends absorbs input bursts. No
// clearing pass is needed after reset. Write outcome_count and equal_share
// only while the block is idle; equal_share should hold 2^24 / n.
module alias_table_builder import abt_pkg::*; #(
	parameter int MAX_OUTCOMES = DEF_MAX_OUTCOMES,
	localparam int IW = $clog2(MAX_OUTCOMES),
	localparam int NW = $clog2(MAX_OUTCOMES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	abt_in_if.sink                item,
	abt_out_if.source             result
);

	logic [CNT_W-1:0]  count_q;
	logic [PROB_W-1:0] share_q;
	logic [31:0]       cnt32, n_full;
	logic [NW-1:0]     n;

	// config registers; the user must write them only between rows, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RST_OUTCOME_COUNT;
			share_q <= RST_EQUAL_SHARE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_OUTCOME_COUNT: count_q <= cfg_data[CNT_W-1:0];
				REG_EQUAL_SHARE:   share_q <= cfg_data[PROB_W-1:0];
				default:           ;
			endcase
		end
	end

	// outcome count held to the range the store supports
	assign cnt32  = 32'(count_q);
	assign n_full = (cnt32 < 32'd2) ? 32'd2 :
		(cnt32 > 32'(MAX_OUTCOMES)) ? 32'(MAX_OUTCOMES) : cnt32;
	assign n      = n_full[NW-1:0];

	// queue channel between the two halves
	abt_item_if #(.IW(IW)) q_ch ();

	abt_front #(.MAX_OUTCOMES(MAX_OUTCOMES)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.n      (n),
		.item   (item),
		.q      (q_ch)
	);

	abt_back #(.MAX_OUTCOMES(MAX_OUTCOMES)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.n      (n),
		.share  (share_q),
		.q      (q_ch),
		.result (result)
	);

endmodule

/* src/abt_front.sv */
// front end: numbers incoming words within the row and queues them
module abt_front import abt_pkg::*; #(
	parameter int MAX_OUTCOMES = DEF_MAX_OUTCOMES,
	localparam int IW = $clog2(MAX_OUTCOMES),
	localparam int NW = $clog2(MAX_OUTCOMES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [NW-1:0] n,
	abt_in_if.sink        item,
	abt_item_if.source    q
);

	typedef struct packed {
		logic [IW-1:0]     idx;
		logic [PROB_W-1:0] prob;
		logic [TAG_W-1:0]  tag;
		logic              first;
		logic              row_last;
	} q_ent_t;

	q_ent_t        q_mem [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    cnt_q;
	logic [NW-1:0] lc_q;

	logic [IW-1:0] idx;
	logic          ends;
	logic          push, pop;

	// slot of this word in the row; a stale count restarts the row
	assign idx  = (lc_q >= n) ? '0 : lc_q[IW-1:0];
	assign ends = item.row_end || ((NW'(idx) + NW'(1)) >= n);

	assign item.ready = (cnt_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign q.valid    = (cnt_q != 2'd0);
	assign pop        = q.valid && q.ready;

	assign q.idx      = q_mem[rd_ptr_q].idx;
	assign q.prob     = q_mem[rd_ptr_q].prob;
	assign q.tag      = q_mem[rd_ptr_q].tag;
	assign q.first    = q_mem[rd_ptr_q].first;
	assign q.row_last = q_mem[rd_ptr_q].row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			lc_q     <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
				lc_q     <= ends ? '0 : NW'(idx) + NW'(1);
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= '{idx: idx, prob: item.probability, tag: item.table_tag,
				first: (idx == '0), row_last: ends};
		end
	end

endmodule

/* src/abt_back.sv */
// back end: residual store, build rounds and result emission
module abt_back import abt_pkg::*; #(
	parameter int MAX_OUTCOMES = DEF_MAX_OUTCOMES,
	localparam int IW = $clog2(MAX_OUTCOMES),
	localparam int NW = $clog2(MAX_OUTCOMES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [NW-1:0]     n,
	input  logic [PROB_W-1:0] share,
	abt_item_if.sink          q,
	abt_out_if.source         result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEL  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_ERD  = 3'd3;
	localparam logic [2:0] ST_EOUT = 3'd4;
	localparam int PW = NW + PROB_W;

	logic [PROB_W-1:0] res_mem   [MAX_OUTCOMES];
	logic [IW-1:0]     alias_mem [MAX_OUTCOMES];
	logic [PROB_W-1:0] keep_mem  [MAX_OUTCOMES];

	logic [2:0]              st_q;
	logic [MAX_OUTCOMES-1:0] live_q, dflag_q, rflag_q, asg_q;
	logic [IW-1:0]           donor_q, recip_q, em_i_q;
	logic [TAG_W-1:0]        tag_q, row_tag_q;
	logic                    out_valid_q;
	logic [PROB_W-1:0]       rd_d_q, rd_r_q, kp_rd_q;
	logic [IW-1:0]           al_rd_q;

	logic [IW-1:0]     o_idx_q, o_alias_q;
	logic [PROB_W-1:0] o_keep_q;
	logic [TAG_W-1:0]  o_tag_q;
	logic              o_inv_q, o_last_q;

	logic [MAX_OUTCOMES-1:0] dcand, rcand;
	logic [IW-1:0]           dsel, rsel, donor_sel;
	logic                    dfound, rfound;
	logic                    take, emitting, can_out, em_last;
	logic [PROB_W-1:0]       res_d, deficit, newd, keep;
	logic [PW-1:0]           prod;

	// lowest-index donor and recipient among the outcomes in use
	always_comb begin
		dsel   = '0;
		rsel   = '0;
		dfound = 1'b0;
		rfound = 1'b0;
		for (int j = 0; j < MAX_OUTCOMES; j++) begin
			dcand[j] = dflag_q[j] && (j < int'(n));
			rcand[j] = rflag_q[j] && (j < int'(n));
		end
		for (int j = MAX_OUTCOMES - 1; j >= 0; j--) begin
			if (dcand[j]) begin
				dsel   = IW'(j);
				dfound = 1'b1;
			end
			if (rcand[j]) begin
				rsel   = IW'(j);
				rfound = 1'b1;
			end
		end
	end
	assign donor_sel = dfound ? dsel : '0;

	// next row may load while results drain, but its last word waits
	assign emitting = (st_q == ST_ERD) || (st_q == ST_EOUT);
	assign q.ready  = (st_q == ST_IDLE) || (emitting && !q.row_last);
	assign take     = q.valid && q.ready;

	// round update: donor gives up the recipient's deficit
	assign res_d   = live_q[donor_q] ? rd_d_q : '0;
	assign deficit = share - rd_r_q;
	assign newd    = (res_d >= deficit) ? res_d - deficit : '0;
	assign prod    = PW'(n) * PW'(rd_r_q);
	assign keep    = (prod > PW'(ONE_Q24)) ? ONE_Q24 : prod[PROB_W-1:0];

	assign can_out = (st_q == ST_EOUT) && (!out_valid_q || result.ready);
	assign em_last = ((NW'(em_i_q) + NW'(1)) == n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			live_q      <= '0;
			dflag_q     <= '0;
			rflag_q     <= '0;
			asg_q       <= '0;
			donor_q     <= '0;
			recip_q     <= '0;
			em_i_q      <= '0;
			tag_q       <= '0;
			row_tag_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				live_q[q.idx]  <= 1'b1;
				dflag_q[q.idx] <= (q.prob >= share);
				rflag_q[q.idx] <= (q.prob != '0) && (q.prob <= share);
				if (q.first) begin
					tag_q <= q.tag;
				end
				if (q.row_last) begin
					// outcomes past the last word hold zero
					for (int j = 0; j < MAX_OUTCOMES; j++) begin
						if (j > int'(q.idx)) begin
							live_q[j]  <= 1'b0;
							dflag_q[j] <= (share == '0);
							rflag_q[j] <= 1'b0;
						end
					end
					asg_q     <= '0;
					row_tag_q <= q.first ? q.tag : tag_q;
				end
			end

			if (can_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (take && q.row_last) begin
						st_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (!rfound) begin
						em_i_q <= '0;
						st_q   <= ST_ERD;
					end else begin
						donor_q <= donor_sel;
						recip_q <= rsel;
						st_q    <= ST_UPD;
					end
				end
				ST_UPD: begin
					live_q[donor_q]  <= 1'b1;
					dflag_q[donor_q] <= (newd >= share);
					rflag_q[donor_q] <= (newd != '0) && (newd <= share);
					// recipient is retired, even when it was its own donor
					live_q[recip_q]  <= 1'b0;
					dflag_q[recip_q] <= 1'b0;
					rflag_q[recip_q] <= 1'b0;
					asg_q[recip_q]   <= 1'b1;
					st_q             <= ST_SEL;
				end
				ST_ERD: begin
					st_q <= ST_EOUT;
				end
				ST_EOUT: begin
					if (can_out) begin
						if (em_last) begin
							st_q <= ST_IDLE;
						end else begin
							em_i_q <= em_i_q + IW'(1);
							st_q   <= ST_ERD;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_mem[q.idx] <= q.prob;
		end else if (st_q == ST_UPD) begin
			res_mem[donor_q] <= newd;
		end
		rd_d_q <= res_mem[donor_sel];
		rd_r_q <= res_mem[rsel];
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_UPD) begin
			alias_mem[recip_q] <= donor_q;
			keep_mem[recip_q]  <= keep;
		end
		al_rd_q <= alias_mem[em_i_q];
		kp_rd_q <= keep_mem[em_i_q];
	end

	always_ff @(posedge clk) begin
		if (can_out) begin
			o_idx_q   <= em_i_q;
			o_alias_q <= asg_q[em_i_q] ? al_rd_q : '0;
			o_keep_q  <= asg_q[em_i_q] ? kp_rd_q : '0;
			o_tag_q   <= row_tag_q;
			o_inv_q   <= !asg_q[em_i_q];
			o_last_q  <= em_last;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.outcome_index    = o_idx_q;
	assign result.alias_index      = o_alias_q;
	assign result.keep_probability = o_keep_q;
	assign result.tag_out          = o_tag_q;
	assign result.entry_invalid    = o_inv_q;
	assign result.last_out         = o_last_q;

endmodule

/* tb/sv/tb.sv */
// testbench for the alias table builder: directed and random rows checked against a local predictor
`timescale 1ns / 1ps

module tb;
	import abt_pkg::*;

	localparam int MAXN = DEF_MAX_OUTCOMES;
	localparam logic [PROB_W-1:0] FULL = ONE_Q24;

	// one expected result word
	typedef struct {
		logic [5:0]        outcome;
		logic [5:0]        alias_idx;
		logic [PROB_W-1:0] keep;
		logic [TAG_W-1:0]  tag;
		logic              invalid;
		logic              last;
	} alias_entry_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	abt_in_if  item ();
	abt_out_if #(.IW(6)) result ();

	alias_table_builder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.item(item.sink),
		.result(result.source)
	);

	// predictor state, a shadow of the block
	logic [CNT_W-1:0]  shadow_count;
	logic [PROB_W-1:0] shadow_share;
	logic [PROB_W-1:0] residual [MAXN];
	logic [5:0]        alias_of [MAXN];
	logic [PROB_W-1:0] keep_of [MAXN];
	logic              assigned [MAXN];
	int                loaded;
	logic [TAG_W-1:0]  row_tag;

	alias_entry_t expected_entries [$];
	int fails;
	int sender_idle;  // percent of cycles the sender holds back
	int sink_stall;   // percent of cycles the receiver stalls

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// generous limit on the whole run
	initial begin
		#20ms;
		$display("tb: FAIL");
		$finish;
	end

	function automatic int active_outcomes();
		if (shadow_count < 2) return 2;
		if (shadow_count > MAXN) return MAXN;
		return int'(shadow_count);
	endfunction

	// build the alias table over the loaded residuals
	function automatic void build_aliases(int n);
		int donor, recip;
		bit found;
		logic [31:0] keep;
		logic [PROB_W-1:0] deficit;
		for (int j = 0; j < MAXN; j++) assigned[j] = 1'b0;
		for (int r = 0; r <= n; r++) begin
			donor = 0;
			recip = 0;
			found = 1'b0;
			for (int j = 0; j < n; j++) begin
				if (residual[j] >= shadow_share) begin
					donor = j;
					break;
				end
			end
			for (int j = 0; j < n; j++) begin
				if (residual[j] > 0 && residual[j] <= shadow_share) begin
					recip = j;
					found = 1'b1;
					break;
				end
			end
			if (!found) break;
			keep = 32'(n) * 32'(residual[recip]);
			if (keep > 32'(FULL)) keep = 32'(FULL);
			alias_of[recip] = 6'(donor);
			keep_of[recip] = PROB_W'(keep);
			assigned[recip] = 1'b1;
			deficit = shadow_share - residual[recip];
			if (residual[donor] >= deficit) residual[donor] = residual[donor] - deficit;
			else residual[donor] = '0;
			residual[recip] = '0;
		end
	endfunction

	// account for one accepted input word, queue the row's results when it closes
	function automatic void predict_word(logic [PROB_W-1:0] prob, logic [TAG_W-1:0] tag,
			logic row_end);
		int n;
		alias_entry_t e;
		n = active_outcomes();
		if (loaded >= n) loaded = 0;
		if (loaded == 0) row_tag = tag;
		residual[loaded] = prob;
		loaded++;
		if (!row_end && loaded < n) return;
		for (int i = loaded; i < n; i++) residual[i] = '0;
		loaded = 0;
		build_aliases(n);
		for (int i = 0; i < n; i++) begin
			e.outcome = 6'(i);
			e.alias_idx = assigned[i] ? alias_of[i] : 6'd0;
			e.keep = assigned[i] ? keep_of[i] : '0;
			e.tag = row_tag;
			e.invalid = !assigned[i];
			e.last = (i + 1 == n);
			expected_entries.push_back(e);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		alias_entry_t e;
		if (arst_n && result.valid && result.ready) begin
			if (expected_entries.size() == 0) begin
				$error("unexpected result word for outcome %0d", result.outcome_index);
				fails++;
			end else begin
				e = expected_entries.pop_front();
				if (result.outcome_index !== e.outcome) begin
					$error("outcome_index exp %0d got %0d", e.outcome, result.outcome_index);
					fails++;
				end
				if (result.alias_index !== e.alias_idx) begin
					$error("alias_index exp %0d got %0d", e.alias_idx, result.alias_index);
					fails++;
				end
				if (result.keep_probability !== e.keep) begin
					$error("keep_probability exp %0d got %0d", e.keep, result.keep_probability);
					fails++;
				end
				if (result.tag_out !== e.tag) begin
					$error("tag_out exp %0d got %0d", e.tag, result.tag_out);
					fails++;
				end
				if (result.entry_invalid !== e.invalid) begin
					$error("entry_invalid exp %0d got %0d", e.invalid, result.entry_invalid);
					fails++;
				end
				if (result.last_out !== e.last) begin
					$error("last_out exp %0d got %0d", e.last, result.last_out);
					fails++;
				end
			end
		end
	end

	// receiver stalls at the phase's rate
	always @(posedge clk) begin
		if (!arst_n) result.ready <= 1'b0;
		else result.ready <= ($urandom_range(99) >= sink_stall);
	end

	// send one input word, gaps at the phase's rate
	task automatic send_word(logic [PROB_W-1:0] prob, logic [TAG_W-1:0] tag, logic row_end);
		while ($urandom_range(99) < sender_idle) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid <= 1'b1;
		item.probability <= prob;
		item.table_tag <= tag;
		item.row_end <= row_end;
		do @(posedge clk); while (!item.ready);
		predict_word(prob, tag, row_end);
	endtask

	// wait for all expected words, then let any build in progress settle
	task automatic drain();
		item.valid <= 1'b0;
		while (expected_entries.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_OUTCOME_COUNT) shadow_count = CNT_W'(data);
		else shadow_share = data;
	endtask

	// set both registers while idle
	task automatic configure(int count, logic [PROB_W-1:0] share);
		drain();
		write_reg(REG_OUTCOME_COUNT, CFG_DATA_W'(count));
		write_reg(REG_EQUAL_SHARE, share);
	endtask

	// send a row; every word of probs, row_end marked on the last one if close is set
	task automatic send_row(logic [PROB_W-1:0] probs [$], logic [TAG_W-1:0] tag, bit close);
		for (int i = 0; i < probs.size(); i++)
			send_word(probs[i], tag, close && (i == probs.size() - 1));
	endtask

	// row whose probabilities sum to one, random split
	task automatic send_normal_row(int n, int len, logic [TAG_W-1:0] tag, bit close);
		logic [PROB_W-1:0] probs [$];
		int left;
		left = FULL;
		for (int i = 0; i < len; i++) begin
			if (i == len - 1) probs.push_back(PROB_W'(left));
			else if ($urandom_range(3) == 0) probs.push_back(PROB_W'(left / (n - i)));
			else probs.push_back(PROB_W'($urandom_range(left / (n - i) * 2 < left ?
				left / (n - i) * 2 : left, 0)));
			left -= probs[i];
		end
		send_row(probs, tag, close);
	endtask

	// row of arbitrary values from zero up to one
	task automatic send_noise_row(int len, logic [TAG_W-1:0] tag, bit close);
		logic [PROB_W-1:0] probs [$];
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(3))
				0: probs.push_back(FULL);
				1: probs.push_back('0);
				default: probs.push_back(PROB_W'($urandom_range(FULL - 1)));
			endcase
		end
		send_row(probs, tag, close);
	endtask

	task automatic test_directed();
		sender_idle = 0;
		sink_stall = 0;
		configure(4, FULL >> 2);
		// uniform row: each outcome is its own donor, keep comes to exactly one
		send_row('{FULL >> 2, FULL >> 2, FULL >> 2, FULL >> 2}, 8'h00, 1'b0);
		// one outcome holds everything, no outcome gets an alias
		send_row('{FULL, 0, 0, 0}, 8'hff, 1'b1);
		// short row closed early, tail taken as zero
		send_row('{25'h0aaaaa, 25'h155555}, 8'h5a, 1'b1);
		// no donor anywhere: donor falls back to outcome zero
		send_row('{25'h000001, 25'h000100, 25'h010000, 25'h0fffff}, 8'ha5, 1'b1);
		// every word at full scale
		send_row('{FULL, FULL, FULL, FULL}, 8'h3c, 1'b1);
		// count below range saturates to two, zero share leaves all unassigned
		configure(0, 0);
		send_row('{FULL >> 1, FULL >> 1}, 8'h01, 1'b1);
		configure(1, FULL);
		send_row('{FULL, 25'h000001}, 8'h80, 1'b0);
		// count above range saturates to the maximum
		configure(127, FULL >> 6);
		send_row('{FULL >> 1, FULL >> 1, FULL}, 8'h7e, 1'b1);
	endtask

	// random rows under the current idling rates
	task automatic test_random_rows(int words);
		int n, len, sent, kind;
		sent = 0;
		while (sent < words) begin
			if ($urandom_range(9) == 0) n = 64;
			else n = $urandom_range(8, 2);
			if ($urandom_range(4) == 0) configure(n, PROB_W'($urandom_range(FULL)));
			else configure(n, PROB_W'(FULL / n));
			repeat ($urandom_range(3, 1)) begin
				kind = $urandom_range(9);
				len = (kind == 0) ? $urandom_range(n, 1) : n;
				if (kind < 7) send_normal_row(n, len, 8'($urandom), kind == 0 || $urandom_range(1));
				else send_noise_row(len, 8'($urandom), kind == 0 || $urandom_range(1));
				sent += len;
			end
		end
	endtask

	initial begin
		fails = 0;
		loaded = 0;
		row_tag = '0;
		shadow_count = RST_OUTCOME_COUNT;
		shadow_share = RST_EQUAL_SHARE;
		for (int i = 0; i < MAXN; i++) residual[i] = '0;
		sender_idle = 0;
		sink_stall = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		item.valid = 1'b0;
		item.probability = '0;
		item.table_tag = '0;
		item.row_end = 1'b0;
		result.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		// no idling
		sender_idle = 0;
		sink_stall = 0;
		test_random_rows(50);
		// sender mostly idle
		sender_idle = 87;
		sink_stall = 0;
		test_random_rows(50);
		// receiver mostly stalled
		sender_idle = 0;
		sink_stall = 87;
		test_random_rows(50);
		// both sides idle
		sender_idle = 29;
		sink_stall = 29;
		test_random_rows(50);

		drain();
		if (fails == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end

endmodule
